// ----- rtl/cpu0_pkg.sv -----
// Package: shared constants, opcodes and sequencer states of the CPU0 executor.
`timescale 1ns / 1ps
package cpu0_pkg;

  // Byte memory size and its address width
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MAW       = $clog2(MEM_BYTES);

  // Register file
  localparam int unsigned RF_DEPTH = 16;
  localparam logic [3:0]  R_ZERO   = 4'd0;
  localparam logic [3:0]  R_SW     = 4'd12;
  localparam logic [3:0]  R_SP     = 4'd13;
  localparam logic [3:0]  R_LR     = 4'd14;
  localparam logic [3:0]  R_PC     = 4'd15;

  // Input word operations
  localparam logic [1:0] ITEM_WRITE = 2'd0;
  localparam logic [1:0] ITEM_START = 2'd1;
  localparam logic [1:0] ITEM_STEP  = 2'd2;

  // Status word masks
  localparam logic [31:0] SW_CLR_NZ = 32'h3FFF_FFFF;
  localparam logic [31:0] SW_N      = 32'h8000_0000;
  localparam logic [31:0] SW_NOT_Z  = 32'hBFFF_FFFF;
  localparam logic [31:0] SW_NOT_N  = 32'h7FFF_FFFF;
  localparam logic [31:0] SW_Z      = 32'h4000_0000;
  localparam logic [31:0] LINK_INIT = 32'hFFFF_FFFF;

  // Opcodes
  localparam logic [7:0] OP_LD    = 8'h00;
  localparam logic [7:0] OP_ST    = 8'h01;
  localparam logic [7:0] OP_LB    = 8'h02;
  localparam logic [7:0] OP_SB    = 8'h03;
  localparam logic [7:0] OP_LDR   = 8'h04;
  localparam logic [7:0] OP_STR   = 8'h05;
  localparam logic [7:0] OP_LBR   = 8'h06;
  localparam logic [7:0] OP_SBR   = 8'h07;
  localparam logic [7:0] OP_LDI   = 8'h08;
  localparam logic [7:0] OP_CMP   = 8'h10;
  localparam logic [7:0] OP_MOV   = 8'h12;
  localparam logic [7:0] OP_ADD   = 8'h13;
  localparam logic [7:0] OP_SUB   = 8'h14;
  localparam logic [7:0] OP_MUL   = 8'h15;
  localparam logic [7:0] OP_DIV   = 8'h16;
  localparam logic [7:0] OP_AND   = 8'h18;
  localparam logic [7:0] OP_OR    = 8'h19;
  localparam logic [7:0] OP_XOR   = 8'h1A;
  localparam logic [7:0] OP_ROL   = 8'h1C;
  localparam logic [7:0] OP_ROR   = 8'h1D;
  localparam logic [7:0] OP_SHL   = 8'h1E;
  localparam logic [7:0] OP_SHR   = 8'h1F;
  localparam logic [7:0] OP_JEQ   = 8'h20;
  localparam logic [7:0] OP_JNE   = 8'h21;
  localparam logic [7:0] OP_JLT   = 8'h22;
  localparam logic [7:0] OP_JGT   = 8'h23;
  localparam logic [7:0] OP_JLE   = 8'h24;
  localparam logic [7:0] OP_JGE   = 8'h25;
  localparam logic [7:0] OP_JMP   = 8'h26;
  localparam logic [7:0] OP_CALL  = 8'h2A;
  localparam logic [7:0] OP_JSUB  = 8'h2B;
  localparam logic [7:0] OP_RET   = 8'h2C;
  localparam logic [7:0] OP_PUSH  = 8'h30;
  localparam logic [7:0] OP_POP   = 8'h31;
  localparam logic [7:0] OP_PSHB  = 8'h32;
  localparam logic [7:0] OP_POPB  = 8'h33;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_RREG,
    S_EXEC,
    S_DIV,
    S_MRD,
    S_MWR,
    S_WB,
    S_WB_SP,
    S_REP,
    S_DONE
  } state_t;

endpackage

// ----- rtl/cpu0_in_if.sv -----
// Interface: input word channel of the CPU0 executor.
`timescale 1ns / 1ps
interface cpu0_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] load_address;
  logic [7:0]  load_byte;

  modport src (output valid, output operation, output load_address, output load_byte,
               input ready);
  modport snk (input valid, input operation, input load_address, input load_byte,
               output ready);
endinterface

// ----- rtl/cpu0_out_if.sv -----
// Interface: result word channel of the CPU0 executor.
`timescale 1ns / 1ps
interface cpu0_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        next_pc;
  logic [31:0]        fetched_word;
  logic [31:0]        status_word;
  logic [3:0]         dest_index;
  logic signed [31:0] dest_value;
  logic               halted;
  logic               bad_opcode;

  modport src (output valid, output next_pc, output fetched_word, output status_word,
               output dest_index, output dest_value, output halted, output bad_opcode,
               input ready);
  modport snk (input valid, input next_pc, input fetched_word, input status_word,
               input dest_index, input dest_value, input halted, input bad_opcode,
               output ready);
endinterface

// ----- rtl/cpu0_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpu0_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cpu0_instruction_executor.sv -----
// Top level: CPU0 core, byte memory, register file and step sequencer.
// Byte write, start and halted step pass from accept straight to the done state, which loads
// the result register once the output is free. A step runs fetch, register read, execute,
// memory access or bit-serial divider, write back of result and SP as needed, report and load.
// One word is in work at a time; input reopens the cycle after the result register loads.
// Reset (synchronous, rst_n low) clears registers, status, PC, halt and start_pc.
`timescale 1ns / 1ps
module cpu0_instruction_executor
  import cpu0_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  cpu0_in_if.snk         in_if,
  cpu0_out_if.src        out_if,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [2:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  state_t state_r, state_nxt;

  logic [5:0]  cnt_r;
  logic [31:0] pc_r, sw_r, ir_r;
  logic        halt_r;
  logic [15:0] start_pc_r;
  logic [31:0] va_r, vb_r, vc_r, vs_r;
  logic [3:0]  wdest_r;
  logic [31:0] wval_r;
  logic        sp_upd_r;
  logic [31:0] sp_new_r;
  logic [31:0] mbase_r, mwdata_r, mdata_r;
  logic        mnb4_r;
  logic [3:0]  rep_idx_r;
  logic [31:0] rep_val_r;
  logic        bad_r, exec_r;
  logic [RF_DEPTH-1:0] rf_vld_r;
  logic [3:0]  rd_idx_r;
  logic [31:0] div_rem_r, div_quo_r, div_dvs_r;
  logic        div_neg_r, div_zero_r;

  // Output register
  logic               out_valid_r;
  logic [31:0]        o_pc_r, o_ir_r, o_sw_r;
  logic [3:0]         o_idx_r;
  logic [31:0]        o_val_r;
  logic               o_halt_r, o_bad_r;

  // Memory ports
  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           rf_we;
  logic [3:0]     rf_waddr, rf_raddr;
  logic [31:0]    rf_wdata, rf_rdata;

  // Instruction fields
  logic [7:0]  opc;
  logic [3:0]  fa, fb, fc;
  logic [4:0]  c5;
  logic [31:0] c16, c24;
  logic        flag_n, flag_z;
  logic [31:0] rv;
  logic        in_fire, out_load;
  logic        last_byte;
  logic [32:0] div_sh, div_diff;
  logic [31:0] div_q;
  logic [63:0] rot_w;
  logic [4:0]  rot_k;

  assign opc    = ir_r[31:24];
  assign fa     = ir_r[23:20];
  assign fb     = ir_r[19:16];
  assign fc     = ir_r[15:12];
  assign c5     = ir_r[4:0];
  assign c16    = {{16{ir_r[15]}}, ir_r[15:0]};
  assign c24    = {{8{ir_r[23]}}, ir_r[23:0]};
  assign flag_n = sw_r[31];
  assign flag_z = sw_r[30];

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign last_byte   = mnb4_r ? (cnt_r == 6'd3) : (cnt_r == 6'd0);

  // Register read value: R0 is zero, status and PC live in flops
  function automatic logic [31:0] rval(input logic [3:0] idx, input logic [31:0] d,
                                       input logic vld, input logic [31:0] sw,
                                       input logic [31:0] pc);
    logic [31:0] v;
    v = vld ? d : 32'd0;
    if (idx == R_ZERO) begin
      v = 32'd0;
    end else if (idx == R_SW) begin
      v = sw;
    end else if (idx == R_PC) begin
      v = pc;
    end
    return v;
  endfunction

  assign rv = rval(rd_idx_r, rf_rdata, rf_vld_r[rd_idx_r], sw_r, pc_r);

  // Divider step: shift in one dividend bit, trial subtract
  assign div_sh   = {div_rem_r, div_quo_r[31]};
  assign div_diff = div_sh - {1'b0, div_dvs_r};
  assign div_q    = {div_quo_r[30:0], ~div_diff[32]};

  // Rotate amount and doubled word for rotates
  assign rot_k = (opc == OP_ROR) ? 5'(6'd32 - {1'b0, c5}) : c5;
  assign rot_w = {vb_r, vb_r} << rot_k;

  cpu0_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpu0_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory port control
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = MAW'(mbase_r + 32'(cnt_r));
    mem_wdata = mwdata_r[31:24];
    mem_raddr = MAW'(mbase_r + 32'(cnt_r));
    rf_we     = 1'b0;
    rf_waddr  = wdest_r;
    rf_wdata  = wval_r;
    rf_raddr  = R_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
          if (in_if.operation == ITEM_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = MAW'(32'(in_if.load_address));
            mem_wdata = in_if.load_byte;
          end else if (in_if.operation == ITEM_START) begin
            rf_we    = 1'b1;
            rf_waddr = R_LR;
            rf_wdata = LINK_INIT;
          end else if (in_if.operation == ITEM_STEP && !halt_r) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        mem_raddr = MAW'(pc_r + 32'(cnt_r));
        if (cnt_r == 6'd4) begin
          state_nxt = S_RREG;
        end
      end
      S_RREG: begin
        case (cnt_r[1:0])
          2'd0:    rf_raddr = fb;
          2'd1:    rf_raddr = fc;
          2'd2:    rf_raddr = fa;
          default: rf_raddr = (opc == OP_RET) ? R_LR : R_SP;
        endcase
        if (cnt_r == 6'd4) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (opc) inside
          OP_LD, OP_LB, OP_LDR, OP_LBR, OP_POP, OP_POPB:     state_nxt = S_MRD;
          OP_ST, OP_SB, OP_STR, OP_SBR, OP_PUSH, OP_PSHB:    state_nxt = S_MWR;
          OP_DIV:                                            state_nxt = S_DIV;
          OP_LDI, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
          OP_ROL, OP_ROR, OP_SHL, OP_SHR, OP_CALL, OP_JSUB:  state_nxt = S_WB;
          default:                                           state_nxt = S_REP;
        endcase
      end
      S_DIV: begin
        if (cnt_r == 6'd31) begin
          state_nxt = S_WB;
        end
      end
      S_MRD: begin
        if (cnt_r != 6'd0 && (mnb4_r ? (cnt_r == 6'd4) : (cnt_r == 6'd1))) begin
          state_nxt = S_WB;
        end
      end
      S_MWR: begin
        mem_we = 1'b1;
        if (last_byte) begin
          state_nxt = sp_upd_r ? S_WB_SP : S_REP;
        end
      end
      S_WB: begin
        rf_we     = (wdest_r != R_ZERO) && (wdest_r != R_SW) && (wdest_r != R_PC);
        state_nxt = sp_upd_r ? S_WB_SP : S_REP;
      end
      S_WB_SP: begin
        rf_we     = 1'b1;
        rf_waddr  = R_SP;
        rf_wdata  = sp_new_r;
        state_nxt = S_REP;
      end
      S_REP: begin
        rf_raddr = rep_idx_r;
        if (cnt_r == 6'd1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: counters, PC, status, halt, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pc_r     <= '0;
      sw_r     <= '0;
      halt_r   <= 1'b0;
      rf_vld_r <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_if.operation == ITEM_START) begin
            pc_r   <= 32'(start_pc_r);
            halt_r <= 1'b0;
          end
        end
        S_FETCH: begin
          if (cnt_r == 6'd4) begin
            pc_r <= pc_r + 32'd4;
          end
        end
        S_EXEC: begin
          case (opc)
            OP_CMP: begin
              if ($signed(va_r) > $signed(vb_r)) begin
                sw_r <= sw_r & SW_CLR_NZ;
              end else if ($signed(va_r) < $signed(vb_r)) begin
                sw_r <= (sw_r | SW_N) & SW_NOT_Z;
              end else begin
                sw_r <= (sw_r & SW_NOT_N) | SW_Z;
              end
            end
            OP_JEQ:  if (flag_z) pc_r <= pc_r + c24;
            OP_JNE:  if (!flag_z) pc_r <= pc_r + c24;
            OP_JLT:  if (flag_n && !flag_z) pc_r <= pc_r + c24;
            OP_JGT:  if (!flag_n && !flag_z) pc_r <= pc_r + c24;
            OP_JLE:  if (flag_n != flag_z) pc_r <= pc_r + c24;
            OP_JGE:  if (!flag_n) pc_r <= pc_r + c24;
            OP_JMP:  pc_r <= pc_r + c24;
            OP_CALL: pc_r <= c24;
            OP_JSUB: pc_r <= pc_r + c24;
            OP_RET: begin
              if (vs_r[31]) begin
                halt_r <= 1'b1;
              end else begin
                pc_r <= vs_r;
              end
            end
            default: ;
          endcase
        end
        S_WB: begin
          if (wdest_r == R_PC) begin
            pc_r <= wval_r;
          end else if (wdest_r == R_SW) begin
            sw_r <= wval_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: operands, memory staging, divider, result values
  always_ff @(posedge clk) begin
    rd_idx_r <= rf_raddr;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          exec_r   <= (in_if.operation == ITEM_STEP) && !halt_r;
          bad_r    <= 1'b0;
          sp_upd_r <= 1'b0;
        end
      end
      S_FETCH: begin
        if (cnt_r != 6'd0) begin
          ir_r <= {ir_r[23:0], mem_rdata};
        end
      end
      S_RREG: begin
        case (cnt_r[2:0])
          3'd1:    vb_r <= rv;
          3'd2:    vc_r <= rv;
          3'd3:    va_r <= rv;
          3'd4:    vs_r <= rv;
          default: ;
        endcase
      end
      S_EXEC: begin
        wdest_r   <= fa;
        rep_idx_r <= (opc == OP_CMP) ? R_SW : fa;
        mdata_r   <= '0;
        mnb4_r    <= 1'b1;
        mwdata_r  <= va_r;
        case (opc)
          OP_LD, OP_ST:   mbase_r <= vb_r + c16;
          OP_LDR, OP_STR: mbase_r <= vb_r + vc_r;
          OP_LB, OP_SB: begin
            mbase_r  <= vb_r + c16;
            mnb4_r   <= 1'b0;
            mwdata_r <= {va_r[7:0], 24'd0};
          end
          OP_LBR, OP_SBR: begin
            mbase_r  <= vb_r + vc_r;
            mnb4_r   <= 1'b0;
            mwdata_r <= {va_r[7:0], 24'd0};
          end
          OP_LDI:  wval_r <= c16;
          OP_MOV:  wval_r <= vb_r;
          OP_ADD:  wval_r <= vb_r + vc_r;
          OP_SUB:  wval_r <= vb_r - vc_r;
          OP_MUL:  wval_r <= vb_r * vc_r;
          OP_AND:  wval_r <= vb_r & vc_r;
          OP_OR:   wval_r <= vb_r | vc_r;
          OP_XOR:  wval_r <= vb_r ^ vc_r;
          OP_ROL, OP_ROR: wval_r <= rot_w[63:32];
          OP_SHL:  wval_r <= vb_r << c5;
          OP_SHR:  wval_r <= vb_r >> c5;
          OP_CALL, OP_JSUB: begin
            wdest_r <= R_LR;
            wval_r  <= pc_r;
          end
          OP_DIV: begin
            div_neg_r  <= vb_r[31] ^ vc_r[31];
            div_zero_r <= (vc_r == 32'd0);
            div_dvs_r  <= vc_r[31] ? (32'd0 - vc_r) : vc_r;
            div_quo_r  <= vb_r[31] ? (32'd0 - vb_r) : vb_r;
            div_rem_r  <= '0;
          end
          OP_PUSH: begin
            mbase_r  <= vs_r - 32'd4;
            sp_new_r <= vs_r - 32'd4;
            sp_upd_r <= 1'b1;
            mwdata_r <= (fa == R_SP) ? (vs_r - 32'd4) : va_r;
          end
          OP_PSHB: begin
            mbase_r  <= vs_r - 32'd1;
            sp_new_r <= vs_r - 32'd1;
            sp_upd_r <= 1'b1;
            mnb4_r   <= 1'b0;
            mwdata_r <= (fa == R_SP) ? {vs_r[7:0] - 8'd1, 24'd0} : {va_r[7:0], 24'd0};
          end
          OP_POP: begin
            mbase_r  <= vs_r;
            sp_new_r <= vs_r + 32'd4;
            sp_upd_r <= 1'b1;
          end
          OP_POPB: begin
            mbase_r  <= vs_r;
            sp_new_r <= vs_r + 32'd1;
            sp_upd_r <= 1'b1;
            mnb4_r   <= 1'b0;
          end
          OP_CMP, OP_JEQ, OP_JNE, OP_JLT, OP_JGT, OP_JLE, OP_JGE, OP_JMP, OP_RET: ;
          default: bad_r <= 1'b1;
        endcase
      end
      S_DIV: begin
        div_quo_r <= div_q;
        div_rem_r <= div_diff[32] ? div_sh[31:0] : div_diff[31:0];
        if (cnt_r == 6'd31) begin
          wval_r <= div_zero_r ? 32'd0 : (div_neg_r ? (32'd0 - div_q) : div_q);
        end
      end
      S_MRD: begin
        if (cnt_r != 6'd0) begin
          mdata_r <= {mdata_r[23:0], mem_rdata};
          wval_r  <= {mdata_r[23:0], mem_rdata};
        end
      end
      S_MWR: begin
        mwdata_r <= {mwdata_r[23:0], 8'd0};
      end
      S_WB: begin
        // Pop into the stack pointer: advance from the loaded value
        if (sp_upd_r && wdest_r == R_SP) begin
          sp_new_r <= wval_r + (mnb4_r ? 32'd4 : 32'd1);
        end
      end
      S_REP: begin
        if (cnt_r == 6'd1) begin
          rep_val_r <= rv;
        end
      end
      default: ;
    endcase
  end

  // Load result word; drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pc_r   <= pc_r;
      o_ir_r   <= exec_r ? ir_r : 32'd0;
      o_sw_r   <= sw_r;
      o_idx_r  <= exec_r ? rep_idx_r : 4'd0;
      o_val_r  <= exec_r ? rep_val_r : 32'd0;
      o_halt_r <= halt_r;
      o_bad_r  <= exec_r && bad_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.next_pc      = o_pc_r;
  assign out_if.fetched_word = o_ir_r;
  assign out_if.status_word  = o_sw_r;
  assign out_if.dest_index   = o_idx_r;
  assign out_if.dest_value   = $signed(o_val_r);
  assign out_if.halted       = o_halt_r;
  assign out_if.bad_opcode   = o_bad_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      start_pc_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(start_pc_r);

endmodule

// ----- rtl/cpu0_chk.sv -----
// Checker: port-level assertions for the CPU0 executor, bound to the top level.
`timescale 1ns / 1ps
module cpu0_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic [31:0] out_fetched_word,
  input logic [3:0]  out_dest_index,
  input logic [31:0] out_dest_value,
  input logic        out_halted,
  input logic        out_bad_opcode
);

  // One word in work at a time: accepting closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after a word was accepted");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_dest_value))
    else $error("stalled result changed");

  // R0 and non-step words report zero
  a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dest_index == 4'd0 |-> out_dest_value == 32'd0)
    else $error("register zero reported nonzero");

  // Unknown opcode comes from a running core and a nonzero opcode field
  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_opcode |-> !out_halted && out_fetched_word[31:24] != 8'd0)
    else $error("bad opcode flag inconsistent");

endmodule

bind cpu0_instruction_executor cpu0_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_next_pc      (out_if.next_pc),
  .out_fetched_word (out_if.fetched_word),
  .out_dest_index   (out_if.dest_index),
  .out_dest_value   (out_if.dest_value),
  .out_halted       (out_if.halted),
  .out_bad_opcode   (out_if.bad_opcode)
);
